>>> sv/hkr_pkg.sv
// Shared types and constants of the held key repeat engine.
package hkr_pkg;

  // Field widths
  localparam int KEY_W  = 10;
  localparam int DEV_W  = 8;
  localparam int MOVE_W = 4;
  localparam int TRIG_W = 32;
  localparam int KIND_W = 3;
  localparam int ACT_W  = 2;
  localparam int CFG_W  = 8;

  // Repeats per tick are capped; the counter holds 0..MAX_REPEATS
  localparam int MAX_REPEATS = 8;
  localparam int CNT_W       = 4;

  // Configuration register indexes and reset values
  localparam logic REG_DELAY    = 1'b0;
  localparam logic REG_INTERVAL = 1'b1;
  localparam logic [CFG_W-1:0] DELAY_RESET    = 8'd15;
  localparam logic [CFG_W-1:0] INTERVAL_RESET = 8'd5;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_PASS    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ACCEPT  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_IGNORED = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REPEAT  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FULL    = 3'd4;

  typedef enum logic [ACT_W-1:0] {
    ACT_PRESS   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_TICK    = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_FLUSH
  } state_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_ROTATE,
    CELL_INSERT,
    CELL_DELETE,
    CELL_CLEAR
  } cell_op_e;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [DEV_W-1:0]  dev;
    logic [MOVE_W-1:0] move;
    logic [TRIG_W-1:0] trigger;
  } slot_t;

  typedef struct packed {
    logic  valid;
    slot_t slot;
  } entry_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    cell_op_e         op;
    logic [KEY_W-1:0] key;
    entry_t           ins;
  } cell_ctrl_t;

endpackage

>>> sv/hkr_cell.sv
// One table cell: holds one held key and moves it to or from its neighbors.
module hkr_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hkr_pkg::cell_ctrl_t ctrl_i,
  input  hkr_pkg::entry_t     left_i,
  input  logic                left_gt_i,
  input  hkr_pkg::entry_t     right_i,
  output hkr_pkg::entry_t     entry_o,
  output logic                gt_o
);

  logic            valid_q, valid_d;
  hkr_pkg::slot_t  slot_q, slot_d;
  logic            gt, ge;

  // Table is kept sorted and packed, so these flags split it in two
  assign gt = !valid_q || (slot_q.key > ctrl_i.key);
  assign ge = valid_q && (slot_q.key >= ctrl_i.key);

  always_comb begin
    valid_d = valid_q;
    slot_d  = slot_q;
    unique case (ctrl_i.op)
      hkr_pkg::CELL_HOLD: begin
      end
      // ring step: take the entry of the right neighbor
      hkr_pkg::CELL_ROTATE: begin
        valid_d = right_i.valid;
        slot_d  = right_i.slot;
      end
      // open a gap at the first larger key and shift the tail right
      hkr_pkg::CELL_INSERT: begin
        if (gt) begin
          if (left_gt_i) begin
            valid_d = left_i.valid;
            slot_d  = left_i.slot;
          end else begin
            valid_d = ctrl_i.ins.valid;
            slot_d  = ctrl_i.ins.slot;
          end
        end
      end
      // close the gap of the matched key
      hkr_pkg::CELL_DELETE: begin
        if (ge) begin
          valid_d = right_i.valid;
          slot_d  = right_i.slot;
        end
      end
      hkr_pkg::CELL_CLEAR: begin
        valid_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign entry_o = '{valid: valid_q, slot: slot_q};
  assign gt_o    = gt;

endmodule

>>> sv/held_key_repeat_engine.sv
// Top level of the held key repeat engine: sequencer, cell ring and result register.
//
// Usage: key events and frame ticks arrive on the input channel (valid/ready),
// one transfer per event. Press and release give one result each; a tick gives
// one repeat result per overdue held key (at most eight, ascending key order,
// last marks the final one) or none; a clear gives none.
// The held keys live in a ring of TABLE_DEPTH cells kept sorted by key. Press,
// release and tick rotate the ring once past the head cell, one cell a cycle
// while no tick scan pauses at a stalled output register; a pass-through press
// goes straight to its result. The next item is taken as soon as the last
// result sits in the output register, even while it waits there.
// Registers repeat_delay and repeat_interval must be written through the plain
// write port only while the block is idle; the block itself does not enforce it.
// Reset empties the table, zeroes the frame clock and loads delay 15 and
// interval 5. When the receiver stalls, the result register holds, a press or
// release waits before its table update, and a tick scan pauses at the next
// repeat it has to hand on.
module held_key_repeat_engine #(
  parameter int TABLE_DEPTH = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [hkr_pkg::ACT_W-1:0]   action_i,
  input  logic [hkr_pkg::KEY_W-1:0]   key_code_i,
  input  logic [hkr_pkg::DEV_W-1:0]   device_id_i,
  input  logic                        is_repeat_i,
  input  logic                        move_valid_i,
  input  logic [hkr_pkg::MOVE_W-1:0]  move_code_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [hkr_pkg::KIND_W-1:0]  kind_o,
  output logic [hkr_pkg::KEY_W-1:0]   key_out_o,
  output logic [hkr_pkg::DEV_W-1:0]   device_out_o,
  output logic [hkr_pkg::MOVE_W-1:0]  move_out_o,
  output logic                        last_o,
  // configuration
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [hkr_pkg::CFG_W-1:0]   cfg_data_i
);

  localparam int StepW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [StepW-1:0] LastStep = StepW'(TABLE_DEPTH - 1);
  localparam logic [hkr_pkg::CNT_W-1:0] CntMax = hkr_pkg::CNT_W'(hkr_pkg::MAX_REPEATS);

  hkr_pkg::state_e                 state_q, state_d;
  hkr_pkg::action_e                op_q, op_d;
  logic                            pass_q, pass_d;
  logic                            hit_q, hit_d;
  logic [StepW-1:0]                step_q, step_d;
  logic [hkr_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic [hkr_pkg::TRIG_W-1:0]      frame_q, frame_d;
  logic [hkr_pkg::CFG_W-1:0]       delay_q, delay_d;
  logic [hkr_pkg::CFG_W-1:0]       interval_q, interval_d;

  // request payload
  logic [hkr_pkg::KEY_W-1:0]       key_q;
  logic [hkr_pkg::DEV_W-1:0]       dev_q;
  logic [hkr_pkg::MOVE_W-1:0]      move_q;

  // held-back repeat, handed on once the next one is known
  logic                            pend_v_q, pend_v_d;
  logic                            pend_ld;
  logic [hkr_pkg::KEY_W-1:0]       pend_key_q;
  logic [hkr_pkg::DEV_W-1:0]       pend_dev_q;
  logic [hkr_pkg::MOVE_W-1:0]      pend_move_q;

  // result register
  logic                            out_valid_q, out_valid_d;
  logic                            out_load;
  logic                            out_free;
  logic [hkr_pkg::KIND_W-1:0]      res_kind, kind_q;
  logic [hkr_pkg::KEY_W-1:0]       res_key, okey_q;
  logic [hkr_pkg::DEV_W-1:0]       res_dev, odev_q;
  logic [hkr_pkg::MOVE_W-1:0]      res_move, omove_q;
  logic                            res_last, olast_q;

  // cell ring
  hkr_pkg::entry_t                 cells [TABLE_DEPTH];
  logic                            gts   [TABLE_DEPTH];
  hkr_pkg::entry_t                 head;
  hkr_pkg::entry_t                 tail_feed;
  hkr_pkg::cell_ctrl_t             ctrl;

  logic                            in_fire;
  logic [hkr_pkg::TRIG_W-1:0]      age;
  logic                            overdue;
  logic                            fire;
  logic                            full;

  assign in_ready_o = (state_q == hkr_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign head       = cells[0];
  assign full       = cells[TABLE_DEPTH-1].valid;

  // wrap-aware compare of the head trigger against the current frame
  assign age     = frame_q - head.slot.trigger;
  assign overdue = (age != '0) && !age[hkr_pkg::TRIG_W-1];
  assign fire    = head.valid && overdue && (cnt_q != CntMax);

  // Cell ring: cell 0 is the head, the last cell is fed by the sequencer
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    hkr_pkg::entry_t left_e;
    hkr_pkg::entry_t right_e;
    logic            left_gt;

    if (i == 0) begin : g_first
      assign left_e  = ctrl.ins;
      assign left_gt = 1'b0;
    end else begin : g_inner_l
      assign left_e  = cells[i-1];
      assign left_gt = gts[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign right_e = tail_feed;
    end else begin : g_inner_r
      assign right_e = cells[i+1];
    end

    hkr_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .left_i    (left_e),
      .left_gt_i (left_gt),
      .right_i   (right_e),
      .entry_o   (cells[i]),
      .gt_o      (gts[i])
    );
  end

  // Sequencer: next state, cell command, result selection
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    pass_d     = pass_q;
    hit_d      = hit_q;
    step_d     = step_q;
    cnt_d      = cnt_q;
    frame_d    = frame_q;
    pend_v_d   = pend_v_q;
    pend_ld    = 1'b0;
    out_load   = 1'b0;
    res_kind   = hkr_pkg::KIND_PASS;
    res_key    = key_q;
    res_dev    = dev_q;
    res_move   = '0;
    res_last   = 1'b1;

    ctrl.op            = hkr_pkg::CELL_HOLD;
    ctrl.key           = key_q;
    ctrl.ins.valid     = 1'b1;
    ctrl.ins.slot.key  = key_q;
    ctrl.ins.slot.dev  = dev_q;
    ctrl.ins.slot.move = move_q;
    ctrl.ins.slot.trigger =
      frame_q + {{(hkr_pkg::TRIG_W - hkr_pkg::CFG_W){1'b0}}, delay_q};
    tail_feed = head;

    unique case (state_q)
      hkr_pkg::ST_IDLE: begin
        if (in_fire) begin
          op_d   = hkr_pkg::action_e'(action_i);
          pass_d = is_repeat_i || !move_valid_i;
          hit_d  = 1'b0;
          step_d = '0;
          unique case (hkr_pkg::action_e'(action_i))
            hkr_pkg::ACT_PRESS: begin
              state_d = (is_repeat_i || !move_valid_i) ? hkr_pkg::ST_COMMIT
                                                       : hkr_pkg::ST_SCAN;
            end
            hkr_pkg::ACT_RELEASE: begin
              state_d = hkr_pkg::ST_SCAN;
            end
            hkr_pkg::ACT_TICK: begin
              frame_d  = frame_q + 1'b1;
              cnt_d    = '0;
              pend_v_d = 1'b0;
              state_d  = hkr_pkg::ST_SCAN;
            end
            hkr_pkg::ACT_CLEAR: begin
              ctrl.op = hkr_pkg::CELL_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end

      // one full turn of the ring past the head cell
      hkr_pkg::ST_SCAN: begin
        if (op_q == hkr_pkg::ACT_TICK) begin
          if (!(fire && pend_v_q && !out_free)) begin
            ctrl.op = hkr_pkg::CELL_ROTATE;
            if (fire) begin
              tail_feed.slot.trigger =
                frame_q + {{(hkr_pkg::TRIG_W - hkr_pkg::CFG_W){1'b0}}, interval_q};
              out_load = pend_v_q;
              res_kind = hkr_pkg::KIND_REPEAT;
              res_key  = pend_key_q;
              res_dev  = pend_dev_q;
              res_move = pend_move_q;
              res_last = 1'b0;
              pend_ld  = 1'b1;
              pend_v_d = 1'b1;
              cnt_d    = cnt_q + 1'b1;
            end
          end
        end else begin
          ctrl.op = hkr_pkg::CELL_ROTATE;
          if (head.valid && (head.slot.key == key_q)) begin
            hit_d = 1'b1;
          end
        end
        if (ctrl.op == hkr_pkg::CELL_ROTATE) begin
          step_d = step_q + 1'b1;
          if (step_q == LastStep) begin
            step_d  = '0;
            state_d = (op_q == hkr_pkg::ACT_TICK) ? hkr_pkg::ST_FLUSH
                                                  : hkr_pkg::ST_COMMIT;
          end
        end
      end

      // press or release outcome, table update with the result transfer
      hkr_pkg::ST_COMMIT: begin
        tail_feed.valid = 1'b0;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = hkr_pkg::ST_IDLE;
          if (op_q == hkr_pkg::ACT_RELEASE) begin
            if (hit_q) begin
              res_kind = hkr_pkg::KIND_ACCEPT;
              ctrl.op  = hkr_pkg::CELL_DELETE;
            end
          end else begin
            priority if (pass_q) begin
              res_kind = hkr_pkg::KIND_PASS;
            end else if (hit_q) begin
              res_kind = hkr_pkg::KIND_IGNORED;
            end else if (full) begin
              res_kind = hkr_pkg::KIND_FULL;
              res_move = move_q;
            end else begin
              res_kind = hkr_pkg::KIND_ACCEPT;
              res_move = move_q;
              ctrl.op  = hkr_pkg::CELL_INSERT;
            end
          end
        end
      end

      // hand on the final repeat of a tick
      hkr_pkg::ST_FLUSH: begin
        if (!pend_v_q) begin
          state_d = hkr_pkg::ST_IDLE;
        end else if (out_free) begin
          out_load = 1'b1;
          res_kind = hkr_pkg::KIND_REPEAT;
          res_key  = pend_key_q;
          res_dev  = pend_dev_q;
          res_move = pend_move_q;
          res_last = 1'b1;
          pend_v_d = 1'b0;
          state_d  = hkr_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = hkr_pkg::ST_IDLE;
      end
    endcase
  end

  // Configuration writes
  always_comb begin
    delay_d    = delay_q;
    interval_d = interval_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        hkr_pkg::REG_DELAY:    delay_d    = cfg_data_i;
        hkr_pkg::REG_INTERVAL: interval_d = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hkr_pkg::ST_IDLE;
      op_q        <= hkr_pkg::ACT_PRESS;
      pass_q      <= 1'b0;
      hit_q       <= 1'b0;
      step_q      <= '0;
      cnt_q       <= '0;
      frame_q     <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      delay_q     <= hkr_pkg::DELAY_RESET;
      interval_q  <= hkr_pkg::INTERVAL_RESET;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      pass_q      <= pass_d;
      hit_q       <= hit_d;
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      frame_q     <= frame_d;
      pend_v_q    <= pend_v_d;
      out_valid_q <= out_valid_d;
      delay_q     <= delay_d;
      interval_q  <= interval_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      key_q  <= key_code_i;
      dev_q  <= device_id_i;
      move_q <= move_code_i;
    end
    if (pend_ld) begin
      pend_key_q  <= head.slot.key;
      pend_dev_q  <= head.slot.dev;
      pend_move_q <= head.slot.move;
    end
    if (out_load) begin
      kind_q  <= res_kind;
      okey_q  <= res_key;
      odev_q  <= res_dev;
      omove_q <= res_move;
      olast_q <= res_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign key_out_o    = okey_q;
  assign device_out_o = odev_q;
  assign move_out_o   = omove_q;
  assign last_o       = olast_q;

`ifndef NO_ASSERTIONS
  // only the final repeat of a tick and single results carry last
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> (kind_o == hkr_pkg::KIND_REPEAT))
    else $error("non-final result that is not a repeat");

  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntMax)
    else $error("repeat count above cap");

  a_tick_clock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (action_i == hkr_pkg::ACT_TICK)) |=>
      (frame_q == $past(frame_q) + 1'b1))
    else $error("frame clock did not advance on tick");

  a_pend_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> ((state_q == hkr_pkg::ST_SCAN) || (state_q == hkr_pkg::ST_FLUSH)))
    else $error("held repeat outside a tick");

  // table stays packed and strictly ascending between items
  for (genvar j = 0; j + 1 < TABLE_DEPTH; j++) begin : g_sorted
    a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
      ((state_q == hkr_pkg::ST_IDLE) && cells[j+1].valid) |->
        (cells[j].valid && (cells[j].slot.key < cells[j+1].slot.key)))
      else $error("cell table not packed and sorted");
  end
`endif

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the held key repeat engine: directed and random key traffic.
module tb_top;

  localparam int TABLE_DEPTH    = 8;
  localparam int SETTLE_CYCLES  = 2 * TABLE_DEPTH + 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int POOL_SIZE      = 12;

  typedef struct packed {
    logic [hkr_pkg::KIND_W-1:0] kind;
    logic [hkr_pkg::KEY_W-1:0]  key;
    logic [hkr_pkg::DEV_W-1:0]  dev;
    logic [hkr_pkg::MOVE_W-1:0] move;
    logic                       last;
  } key_result_t;

  // DUT connections; every input starts at a known value
  logic                         clk_i        = 1'b0;
  logic                         rst_ni       = 1'b0;
  logic                         in_valid_i   = 1'b0;
  logic [hkr_pkg::ACT_W-1:0]    action_i     = '0;
  logic [hkr_pkg::KEY_W-1:0]    key_code_i   = '0;
  logic [hkr_pkg::DEV_W-1:0]    device_id_i  = '0;
  logic                         is_repeat_i  = 1'b0;
  logic                         move_valid_i = 1'b0;
  logic [hkr_pkg::MOVE_W-1:0]   move_code_i  = '0;
  logic                         out_ready_i  = 1'b0;
  logic                         cfg_we_i     = 1'b0;
  logic                         cfg_index_i  = 1'b0;
  logic [hkr_pkg::CFG_W-1:0]    cfg_data_i   = '0;
  logic                         in_ready_o;
  logic                         out_valid_o;
  logic [hkr_pkg::KIND_W-1:0]   kind_o;
  logic [hkr_pkg::KEY_W-1:0]    key_out_o;
  logic [hkr_pkg::DEV_W-1:0]    device_out_o;
  logic [hkr_pkg::MOVE_W-1:0]   move_out_o;
  logic                         last_o;

  // Predicted state of the held key table
  logic                         held_valid [TABLE_DEPTH];
  hkr_pkg::slot_t               held_slot  [TABLE_DEPTH];
  logic [hkr_pkg::TRIG_W-1:0]   frame_now;
  logic [hkr_pkg::CFG_W-1:0]    delay_frames;
  logic [hkr_pkg::CFG_W-1:0]    interval_frames;
  key_result_t                  expected_q [$];
  key_result_t                  oldest_expected;

  // Traffic shaping
  logic [hkr_pkg::KEY_W-1:0]    key_pool [POOL_SIZE];
  int                           burst_left   = 0;
  bit                           sender_gaps  = 1'b0;
  int                           stall_pct    = 0;
  int                           stall_left   = 0;
  int                           quiet_cycles = 0;
  int                           errors       = 0;

  held_key_repeat_engine #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .key_code_i  (key_code_i),
    .device_id_i (device_id_i),
    .is_repeat_i (is_repeat_i),
    .move_valid_i(move_valid_i),
    .move_code_i (move_code_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .key_out_o   (key_out_o),
    .device_out_o(device_out_o),
    .move_out_o  (move_out_o),
    .last_o      (last_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Queue one expected result
  function automatic void expect_result(input logic [hkr_pkg::KIND_W-1:0] kind,
                                        input logic [hkr_pkg::KEY_W-1:0] key,
                                        input logic [hkr_pkg::DEV_W-1:0] dev,
                                        input logic [hkr_pkg::MOVE_W-1:0] move,
                                        input logic last);
    key_result_t r;
    r.kind = kind;
    r.key  = key;
    r.dev  = dev;
    r.move = move;
    r.last = last;
    expected_q = {expected_q, r};
  endfunction

  // Wrap-aware: trigger lies strictly before the current frame
  function automatic logic is_overdue(input logic [hkr_pkg::TRIG_W-1:0] trig);
    logic [hkr_pkg::TRIG_W-1:0] d;
    d = frame_now - trig;
    return (d != '0) && !d[hkr_pkg::TRIG_W-1];
  endfunction

  // Update the predicted table for one accepted event and queue its results
  function automatic void predict_event(input hkr_pkg::action_e act,
                                        input logic [hkr_pkg::KEY_W-1:0] key,
                                        input logic [hkr_pkg::DEV_W-1:0] dev,
                                        input logic is_rep,
                                        input logic mvalid,
                                        input logic [hkr_pkg::MOVE_W-1:0] move);
    int                        hit;
    int                        free_slot;
    int                        best;
    int                        n;
    logic [hkr_pkg::KEY_W-1:0] prev;
    logic                      have_prev;
    logic                      done;
    hkr_pkg::slot_t            cand;
    hkr_pkg::slot_t            chosen;
    hkr_pkg::slot_t            fired [hkr_pkg::MAX_REPEATS];
    hit       = -1;
    free_slot = -1;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      cand = held_slot[i];
      if (held_valid[i] && cand.key == key && hit < 0) hit = i;
      if (!held_valid[i] && free_slot < 0) free_slot = i;
    end
    case (act)
      hkr_pkg::ACT_PRESS: begin
        if (is_rep || !mvalid) begin
          expect_result(hkr_pkg::KIND_PASS, key, dev, '0, 1'b1);
        end else if (hit >= 0) begin
          expect_result(hkr_pkg::KIND_IGNORED, key, dev, '0, 1'b1);
        end else if (free_slot < 0) begin
          expect_result(hkr_pkg::KIND_FULL, key, dev, move, 1'b1);
        end else begin
          cand.key     = key;
          cand.dev     = dev;
          cand.move    = move;
          cand.trigger = frame_now + delay_frames;
          held_slot[free_slot]  = cand;
          held_valid[free_slot] = 1'b1;
          expect_result(hkr_pkg::KIND_ACCEPT, key, dev, move, 1'b1);
        end
      end
      hkr_pkg::ACT_RELEASE: begin
        if (hit >= 0) begin
          held_valid[hit] = 1'b0;
          expect_result(hkr_pkg::KIND_ACCEPT, key, dev, '0, 1'b1);
        end else begin
          expect_result(hkr_pkg::KIND_PASS, key, dev, '0, 1'b1);
        end
      end
      hkr_pkg::ACT_CLEAR: begin
        for (int i = 0; i < TABLE_DEPTH; i++) held_valid[i] = 1'b0;
      end
      default: begin
        // Frame tick: fire overdue keys in ascending key order, re-arm each
        frame_now = frame_now + 1;
        n         = 0;
        prev      = '0;
        have_prev = 1'b0;
        done      = 1'b0;
        while (!done && n < hkr_pkg::MAX_REPEATS) begin
          best = -1;
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            cand = held_slot[i];
            if (held_valid[i] && is_overdue(cand.trigger) &&
                (!have_prev || cand.key > prev) &&
                (best < 0 || cand.key < chosen.key)) begin
              best   = i;
              chosen = cand;
            end
          end
          if (best < 0) begin
            done = 1'b1;
          end else begin
            fired[n]       = chosen;
            chosen.trigger = frame_now + interval_frames;
            held_slot[best] = chosen;
            prev      = chosen.key;
            have_prev = 1'b1;
            n++;
          end
        end
        for (int j = 0; j < n; j++)
          expect_result(hkr_pkg::KIND_REPEAT, fired[j].key, fired[j].dev,
                        fired[j].move, j == n - 1);
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $time);
    errors++;
  endtask

  // Send one event: bursts with random gaps when sender_gaps is set, valid held until the transfer
  task automatic send_event(input hkr_pkg::action_e act,
                            input logic [hkr_pkg::KEY_W-1:0] key,
                            input logic [hkr_pkg::DEV_W-1:0] dev, input logic is_rep,
                            input logic mvalid, input logic [hkr_pkg::MOVE_W-1:0] move);
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (sender_gaps) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    action_i     <= act;
    key_code_i   <= key;
    device_id_i  <= dev;
    is_repeat_i  <= is_rep;
    move_valid_i <= mvalid;
    move_code_i  <= move;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_event(act, key, dev, is_rep, mvalid, move);
  endtask

  // Drop valid, drain every expected result, then let a clear finish
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write both timing registers back to back
  task automatic configure(input logic [hkr_pkg::CFG_W-1:0] delay,
                           input logic [hkr_pkg::CFG_W-1:0] interval);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= hkr_pkg::REG_DELAY;
    cfg_data_i  <= delay;
    @(posedge clk_i);
    delay_frames = delay;
    @(negedge clk_i);
    cfg_index_i <= hkr_pkg::REG_INTERVAL;
    cfg_data_i  <= interval;
    @(posedge clk_i);
    interval_frames = interval;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Plain press and release handling at reset timing
  task automatic test_press_release();
    sender_gaps = 1'b1;
    stall_pct   = 30;
    send_event(hkr_pkg::ACT_PRESS,   10'd0,    8'd0,   1'b0, 1'b1, 4'd0);
    send_event(hkr_pkg::ACT_PRESS,   10'd1023, 8'd255, 1'b0, 1'b1, 4'd9);
    send_event(hkr_pkg::ACT_PRESS,   10'd0,    8'd170, 1'b0, 1'b1, 4'd5);   // already held
    send_event(hkr_pkg::ACT_PRESS,   10'd341,  8'd85,  1'b1, 1'b1, 4'd7);   // external repeat
    send_event(hkr_pkg::ACT_PRESS,   10'd682,  8'd1,   1'b0, 1'b0, 4'd8);   // no focus move
    send_event(hkr_pkg::ACT_RELEASE, 10'd77,   8'd2,   1'b0, 1'b1, 4'd3);   // not held
    send_event(hkr_pkg::ACT_TICK,    10'd5,    8'd3,   1'b1, 1'b0, 4'd2);   // nothing overdue
    send_event(hkr_pkg::ACT_RELEASE, 10'd0,    8'd4,   1'b0, 1'b1, 4'd1);
    send_event(hkr_pkg::ACT_CLEAR,   10'd1023, 8'd255, 1'b1, 1'b1, 4'd15);
  endtask

  // Fill past capacity, then fire all keys with zero delay and interval
  task automatic test_full_table_and_zero_timing();
    logic [hkr_pkg::KEY_W-1:0] keys [TABLE_DEPTH];
    keys = '{10'd1023, 10'd900, 10'd513, 10'd512, 10'd300, 10'd64, 10'd1, 10'd0};
    wait_idle();
    configure(8'd0, 8'd0);
    sender_gaps = 1'b0;
    stall_pct   = 50;
    for (int i = 0; i < TABLE_DEPTH; i++)
      send_event(hkr_pkg::ACT_PRESS, keys[i], hkr_pkg::DEV_W'(8'hF0 + i), 1'b0, 1'b1,
                 hkr_pkg::MOVE_W'(i + 2));
    send_event(hkr_pkg::ACT_PRESS, 10'd700, 8'd99, 1'b0, 1'b1, 4'd6);    // table full
    send_event(hkr_pkg::ACT_TICK,  10'd0,   8'd0,  1'b0, 1'b0, 4'd0);    // all eight repeat
    send_event(hkr_pkg::ACT_TICK,  10'd0,   8'd0,  1'b0, 1'b0, 4'd0);    // zero interval again
    send_event(hkr_pkg::ACT_CLEAR, 10'd0,   8'd0,  1'b0, 1'b0, 4'd0);
  endtask

  // Random traffic over a small key set so keys get held, repeated and released
  task automatic test_random_traffic(input logic [hkr_pkg::CFG_W-1:0] delay,
                                     input logic [hkr_pkg::CFG_W-1:0] interval,
                                     input int count, input bit gaps, input int stall);
    int                        roll;
    logic [hkr_pkg::KEY_W-1:0] key;
    hkr_pkg::action_e          act;
    wait_idle();
    configure(delay, interval);
    sender_gaps = gaps;
    stall_pct   = stall;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = hkr_pkg::KEY_W'($urandom);
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) key = hkr_pkg::KEY_W'($urandom);
      else key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (roll < 34)      act = hkr_pkg::ACT_PRESS;
      else if (roll < 58) act = hkr_pkg::ACT_RELEASE;
      else if (roll < 96) act = hkr_pkg::ACT_TICK;
      else                act = hkr_pkg::ACT_CLEAR;
      send_event(act, key, hkr_pkg::DEV_W'($urandom), $urandom_range(0, 9) == 0,
                 $urandom_range(0, 9) != 0, hkr_pkg::MOVE_W'($urandom_range(0, 9)));
    end
  endtask

  // Receiver: random stalls of random length, never when stall_pct is zero
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(0, 7);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result, kind", '0, 32'(kind_o));
      end else begin
        oldest_expected = expected_q.pop_front();
        if (kind_o !== oldest_expected.kind)
          report_mismatch("kind", 32'(oldest_expected.kind), 32'(kind_o));
        if (key_out_o !== oldest_expected.key)
          report_mismatch("key_out", 32'(oldest_expected.key), 32'(key_out_o));
        if (device_out_o !== oldest_expected.dev)
          report_mismatch("device_out", 32'(oldest_expected.dev), 32'(device_out_o));
        if (move_out_o !== oldest_expected.move)
          report_mismatch("move_out", 32'(oldest_expected.move), 32'(move_out_o));
        if (last_o !== oldest_expected.last)
          report_mismatch("last", 32'(oldest_expected.last), 32'(last_o));
      end
    end
  end

  // Watchdog: too long without any transfer on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL held_key_repeat_engine");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) held_valid[i] = 1'b0;
    frame_now       = '0;
    delay_frames    = hkr_pkg::DELAY_RESET;
    interval_frames = hkr_pkg::INTERVAL_RESET;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_press_release();
    test_full_table_and_zero_timing();
    test_random_traffic(hkr_pkg::DELAY_RESET, hkr_pkg::INTERVAL_RESET, 60, 1'b1, 20);
    test_random_traffic(8'd1,   8'd1,   60, 1'b0, 0);
    test_random_traffic(8'd255, 8'd255, 50, 1'b1, 40);
    test_random_traffic(8'd255, 8'd1,   60, 1'b1, 10);
    test_random_traffic(8'd2,   8'd255, 60, 1'b0, 50);
    test_random_traffic(8'd4,   8'd3,   60, 1'b1, 30);

    wait_idle();
    if (errors == 0) begin
      $display("PASS held_key_repeat_engine");
    end else begin
      $display("FAIL held_key_repeat_engine");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/hkr_pkg.sv
sv/hkr_cell.sv
sv/held_key_repeat_engine.sv
tb/tb_top.sv
